### design/fst_pkg.sv
// fst_pkg: shared types, codes and constants for the flow session table
// used by fst_cell and flow_session_table; no dependencies
`default_nettype none

package fst_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 64;
  // index field wide enough for the largest supported table (4096 entries)
  localparam int IDX_MAX_W = 12;

  localparam logic [15:0] TIMEOUT_RESET = 16'd120;
  localparam logic [6:0]  COUNT_MAX     = 7'd127;
  localparam logic [31:0] SESSION_FIRST = 32'd1;

  // request opcodes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_SWEEP  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // result status codes
  localparam logic [2:0] STATUS_HIT     = 3'd0;
  localparam logic [2:0] STATUS_CREATED = 3'd1;
  localparam logic [2:0] STATUS_FULL    = 3'd2;
  localparam logic [2:0] STATUS_TICK    = 3'd3;
  localparam logic [2:0] STATUS_SWEEP   = 3'd4;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  protocol_number;
  } fst_key_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  protocol_number;
  } fst_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] session_number;
    logic [6:0]  expired_count;
  } fst_rsp_t;

  // token that walks the cell row, one cell per cycle
  typedef struct packed {
    logic                 active;
    logic                 sweep;
    fst_key_t             key;
    logic                 hit;
    logic [31:0]          session;
    logic                 free_found;
    logic [IDX_MAX_W-1:0] free_idx;
    logic [6:0]           count;
  } fst_tok_t;

  // allocation write broadcast to all cells
  typedef struct packed {
    logic                 en;
    logic [IDX_MAX_W-1:0] idx;
    fst_key_t             key;
    logic [31:0]          session;
    logic [31:0]          seen_at;
  } fst_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } fst_state_t;

endpackage

`default_nettype wire

### design/flow_session_table.sv
// flow session table: lookup/create, one-second tick and idle-expiry sweep
// lookup and sweep: the token walks the cell row one cell per cycle, then the
//   result is registered in res and then in rsp; one item at a time
// tick: result registered in res, then in rsp; unused opcode: taken, no result
// rst (synchronous) empties the table, zeroes seconds, session numbers restart at 1
// depends on fst_pkg and fst_cell
`default_nettype none

module flow_session_table #(
  parameter int TABLE_ENTRIES = fst_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_stall,
  input  fst_pkg::fst_req_t req,
  output logic              rsp_valid,
  input  wire               rsp_stall,
  output fst_pkg::fst_rsp_t rsp,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [15:0]        cfg_data
);
  import fst_pkg::*;

  fst_state_t  state;
  fst_state_t  state_next;
  logic [15:0] timeout;
  logic [31:0] seconds;
  logic [31:0] next_session;
  fst_rsp_t    res;
  fst_tok_t    tok [TABLE_ENTRIES+1];
  fst_tok_t    tok_end;
  fst_wr_t     wr;
  fst_key_t    req_key;

  logic req_take;
  logic walk_done;
  logic rsp_load;
  logic alloc;

  assign cfg_ready = 1'b1;
  assign req_take  = req_valid && !req_stall;
  assign tok_end   = tok[TABLE_ENTRIES];
  assign walk_done = (state == ST_WALK) && tok_end.active;
  assign alloc     = walk_done && !tok_end.sweep && !tok_end.hit && tok_end.free_found;

  assign req_key.source_address      = req.source_address;
  assign req_key.destination_address = req.destination_address;
  assign req_key.source_port         = req.source_port;
  assign req_key.destination_port    = req.destination_port;
  assign req_key.protocol_number     = req.protocol_number;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.opcode == OP_LOOKUP || req.opcode == OP_SWEEP) begin
            state_next = ST_WALK;
          end else if (req.opcode == OP_TICK) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if (tok_end.active) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the control
  always_comb begin
    req_stall = 1'b1;
    rsp_load  = 1'b0;
    unique case (state)
      ST_IDLE: req_stall = 1'b0;
      ST_WALK: req_stall = 1'b1;
      ST_DONE: rsp_load  = !rsp_valid || !rsp_stall;
      default: req_stall = 1'b1;
    endcase
  end

  always_comb begin
    wr.en      = alloc;
    wr.idx     = tok_end.free_idx;
    wr.key     = tok_end.key;
    wr.session = next_session;
    wr.seen_at = seconds;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      timeout      <= TIMEOUT_RESET;
      seconds      <= 32'd0;
      next_session <= SESSION_FIRST;
      rsp_valid    <= 1'b0;
      tok[0].active <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        timeout <= cfg_data;
      end
      if (req_take && req.opcode == OP_TICK) begin
        seconds <= seconds + 32'd1;
      end
      if (alloc) begin
        next_session <= next_session + 32'd1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      tok[0].active     <= req_take && (req.opcode == OP_LOOKUP || req.opcode == OP_SWEEP);
      tok[0].sweep      <= req.opcode == OP_SWEEP;
      tok[0].key        <= req_key;
      tok[0].hit        <= 1'b0;
      tok[0].session    <= 32'd0;
      tok[0].free_found <= 1'b0;
      tok[0].free_idx   <= '0;
      tok[0].count      <= 7'd0;
    end
  end

  // pending result, held until the output register frees up
  always_ff @(posedge clk) begin
    if (req_take && req.opcode == OP_TICK) begin
      res.status         <= STATUS_TICK;
      res.session_number <= 32'd0;
      res.expired_count  <= 7'd0;
    end else if (walk_done) begin
      if (tok_end.sweep) begin
        res.status         <= STATUS_SWEEP;
        res.session_number <= 32'd0;
        res.expired_count  <= tok_end.count;
      end else if (tok_end.hit) begin
        res.status         <= STATUS_HIT;
        res.session_number <= tok_end.session;
        res.expired_count  <= 7'd0;
      end else if (tok_end.free_found) begin
        res.status         <= STATUS_CREATED;
        res.session_number <= next_session;
        res.expired_count  <= 7'd0;
      end else begin
        res.status         <= STATUS_FULL;
        res.session_number <= 32'd0;
        res.expired_count  <= 7'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    fst_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .seconds (seconds),
      .timeout (timeout),
      .wr      (wr),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

`ifndef SYNTHESIS
  // a token leaves the row only while the control waits for it
  a_tok_in_walk: assert property (@(posedge clk) disable iff (rst)
    tok_end.active |-> state == ST_WALK)
    else $error("token left cell row outside walk");

  // each created session advances the session counter by exactly one
  a_session_step: assert property (@(posedge clk) disable iff (rst)
    alloc |=> next_session == $past(next_session) + 32'd1)
    else $error("session counter did not advance on create");

  // an allocation always produces a created result
  a_alloc_result: assert property (@(posedge clk) disable iff (rst)
    alloc |=> state == ST_DONE && res.status == STATUS_CREATED)
    else $error("allocation without created result");

  // seconds only move on a tick transfer
  a_seconds_tick: assert property (@(posedge clk) disable iff (rst)
    !(req_valid && !req_stall && req.opcode == OP_TICK) |=> $stable(seconds))
    else $error("seconds changed without tick");
`endif

endmodule

`default_nettype wire

### design/fst_cell.sv
// fst_cell: one table entry plus the token register toward the next cell
// depends on fst_pkg
`default_nettype none

module fst_cell #(
  parameter int CELL_INDEX = 0
) (
  input  wire              clk,
  input  wire              rst,
  input  wire [31:0]       seconds,
  input  wire [15:0]       timeout,
  input  fst_pkg::fst_wr_t wr,
  input  fst_pkg::fst_tok_t tok_in,
  output fst_pkg::fst_tok_t tok_out
);
  import fst_pkg::*;

  logic        valid;
  fst_key_t    key;
  logic [31:0] session;
  logic [31:0] seen_at;

  logic        wr_here;
  logic        hit_here;
  logic        free_here;
  logic        exp_here;
  logic [31:0] age;
  fst_tok_t    tok_next;

  assign age       = seconds - seen_at;
  assign wr_here   = wr.en && (wr.idx == IDX_MAX_W'(CELL_INDEX));
  assign hit_here  = tok_in.active && !tok_in.sweep && valid && !tok_in.hit
                     && (key == tok_in.key);
  assign free_here = tok_in.active && !tok_in.sweep && !valid && !tok_in.free_found;
  assign exp_here  = tok_in.active && tok_in.sweep && valid && (age > {16'd0, timeout});

  always_comb begin
    tok_next = tok_in;
    if (hit_here) begin
      tok_next.hit     = 1'b1;
      tok_next.session = session;
    end
    if (free_here) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = IDX_MAX_W'(CELL_INDEX);
    end
    if (exp_here && (tok_in.count != COUNT_MAX)) begin
      tok_next.count = tok_in.count + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (wr_here) begin
        valid <= 1'b1;
      end else if (exp_here) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      key     <= wr.key;
      session <= wr.session;
      seen_at <= wr.seen_at;
    end else if (hit_here) begin
      seen_at <= seconds;
    end
  end

endmodule

`default_nettype wire
